[rtl/hpbl_pkg.sv]
package hpbl_pkg;

	localparam logic [15:0] TIMEOUT_RESET = 16'd10000;
	localparam logic [7:0]  PARITY_FAIL_DRIVE = 8'hff;
	localparam logic [15:0] COUNT_MAX = 16'hffff;

	typedef enum logic [1:0] {
		KIND_TICK  = 2'd0,
		KIND_SEND  = 2'd1,
		KIND_READ  = 2'd2,
		KIND_CLEAR = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ERR_OK           = 2'd0,
		ERR_SEND_TIMEOUT = 2'd1,
		ERR_READ_TIMEOUT = 2'd2,
		ERR_REPLY_TIMEOUT = 2'd3
	} err_t;

	typedef enum logic [6:0] {
		PH_IDLE    = 7'b0000001,
		PH_SEND_HI = 7'b0000010,
		PH_SEND_LO = 7'b0000100,
		PH_RD_HI1  = 7'b0001000,
		PH_RD_LO1  = 7'b0010000,
		PH_RD_HI2  = 7'b0100000,
		PH_RD_LO2  = 7'b1000000
	} phase_t;

	typedef struct packed {
		logic        ack_pending;
		logic        engine_busy;
		logic [15:0] parity_errors;
		logic [7:0]  received_byte;
		err_t        error_code;
		logic        done_res;
		logic        select_drive;
		logic [7:0]  data_lines;
	} result_t;

endpackage

[rtl/hpbl_engine.sv]
module hpbl_engine #(
	parameter logic [15:0] TIMEOUT_INIT = hpbl_pkg::TIMEOUT_RESET
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [15:0]         cfg_data,
	input  logic                take,
	input  hpbl_pkg::kind_t     kind,
	input  logic [7:0]          send_data,
	input  logic                ack_pin,
	input  logic                select_pin,
	input  logic                paper_pin,
	input  logic                busy_pin,
	output hpbl_pkg::result_t   res
);
	import hpbl_pkg::*;

	logic [15:0] limit_q;
	phase_t      phase_q, phase_n;
	logic [16:0] poll_q, poll_n;
	logic [7:0]  byte_q, byte_n;
	logic        pbad_q, pbad_n;
	logic [15:0] perr_q, perr_n;
	logic [7:0]  drive_q, drive_n;
	logic        sel_q, sel_n;
	logic        done;
	err_t        err;
	logic [7:0]  rx;
	logic        nbusy;

	assign nbusy = ~busy_pin;

	always_comb begin
		phase_n = phase_q;
		poll_n  = poll_q;
		byte_n  = byte_q;
		pbad_n  = pbad_q;
		perr_n  = perr_q;
		drive_n = drive_q;
		sel_n   = sel_q;
		done    = 1'b0;
		err     = ERR_OK;
		rx      = 8'd0;
		if (phase_q == PH_IDLE) begin
			case (kind)
				KIND_SEND: begin
					drive_n = send_data;
					sel_n   = 1'b1;
					poll_n  = 17'd0;
					phase_n = PH_SEND_HI;
				end
				KIND_READ: begin
					poll_n  = 17'd0;
					byte_n  = 8'd0;
					pbad_n  = 1'b0;
					phase_n = PH_RD_HI1;
				end
				KIND_CLEAR: begin
					drive_n = 8'd0;
					sel_n   = 1'b0;
					perr_n  = 16'd0;
					done    = 1'b1;
				end
				default: begin
				end
			endcase
		end else if (poll_q > {1'b0, limit_q}) begin
			case (phase_q)
				PH_SEND_HI: begin
					sel_n = 1'b0;
					err   = ERR_SEND_TIMEOUT;
				end
				PH_SEND_LO: err = ERR_SEND_TIMEOUT;
				PH_RD_LO1: begin
					sel_n = 1'b0;
					err   = ERR_READ_TIMEOUT;
				end
				PH_RD_LO2: begin
					sel_n = 1'b0;
					err   = ERR_REPLY_TIMEOUT;
				end
				default: err = ERR_READ_TIMEOUT;
			endcase
			done    = 1'b1;
			phase_n = PH_IDLE;
			poll_n  = 17'd0;
		end else begin
			poll_n = poll_q + 17'd1;
			case (phase_q)
				PH_SEND_HI: begin
					if (ack_pin) begin
						sel_n   = 1'b0;
						poll_n  = 17'd0;
						phase_n = PH_SEND_LO;
					end
				end
				PH_SEND_LO: begin
					if (!ack_pin) begin
						done    = 1'b1;
						poll_n  = 17'd0;
						phase_n = PH_IDLE;
					end
				end
				PH_RD_HI1: begin
					if (ack_pin) begin
						byte_n  = {5'd0, nbusy, paper_pin, select_pin};
						sel_n   = 1'b1;
						poll_n  = 17'd0;
						phase_n = PH_RD_LO1;
					end
				end
				PH_RD_LO1: begin
					if (!ack_pin) begin
						byte_n  = byte_q | {2'd0, nbusy, paper_pin, select_pin, 3'd0};
						sel_n   = 1'b0;
						poll_n  = 17'd0;
						phase_n = PH_RD_HI2;
					end
				end
				PH_RD_HI2: begin
					if (ack_pin) begin
						byte_n = byte_q | {paper_pin, select_pin, 6'd0};
						if (nbusy != (^byte_n)) begin
							drive_n = PARITY_FAIL_DRIVE;
							pbad_n  = 1'b1;
							if (perr_q != COUNT_MAX) begin
								perr_n = perr_q + 16'd1;
							end
						end else begin
							drive_n = 8'd0;
							pbad_n  = 1'b0;
						end
						sel_n   = 1'b1;
						poll_n  = 17'd0;
						phase_n = PH_RD_LO2;
					end
				end
				PH_RD_LO2: begin
					if (!ack_pin) begin
						sel_n  = 1'b0;
						poll_n = 17'd0;
						if (pbad_q) begin
							pbad_n  = 1'b0;
							byte_n  = 8'd0;
							phase_n = PH_RD_HI1;
						end else begin
							done    = 1'b1;
							rx      = byte_q;
							phase_n = PH_IDLE;
						end
					end
				end
				default: begin
					phase_n = PH_IDLE;
					poll_n  = 17'd0;
				end
			endcase
		end
	end

	always_comb begin
		res.data_lines    = drive_n;
		res.select_drive  = sel_n;
		res.done_res      = done;
		res.error_code    = err;
		res.received_byte = rx;
		res.parity_errors = perr_n;
		res.engine_busy   = (phase_n != PH_IDLE);
		res.ack_pending   = ack_pin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= TIMEOUT_INIT;
			phase_q <= PH_IDLE;
			poll_q  <= 17'd0;
			byte_q  <= 8'd0;
			pbad_q  <= 1'b0;
			perr_q  <= 16'd0;
			drive_q <= 8'd0;
			sel_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_data;
			end
			if (take) begin
				phase_q <= phase_n;
				poll_q  <= poll_n;
				byte_q  <= byte_n;
				pbad_q  <= pbad_n;
				perr_q  <= perr_n;
				drive_q <= drive_n;
				sel_q   <= sel_n;
			end
		end
	end

endmodule

[rtl/handshake_port_byte_link.sv]
// Host-side engine for a byte link carried on parallel-port handshake lines.
// Each input transfer is one poll of the sampled status pins, or a command
// (start send, start read, clear) given while the engine is idle; commands
// given while busy count as polls. Every input transfer yields exactly one
// output transfer showing the line drive and status after that poll. The
// engine takes one transfer per clock cycle unless its output register is
// stalled: the state machine updates in the cycle of acceptance and the result
// sits in a single output register, which frees in the same cycle that the
// downstream side takes it. The timeout limit may be written only while idle.
module handshake_port_byte_link #(
	parameter logic [15:0] TIMEOUT_INIT = hpbl_pkg::TIMEOUT_RESET
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,   // timeout_limit
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,    // send_data[7:0], ack_pin, select_pin, paper_pin,
	                                // busy_pin, zero fill
	input  logic [1:0]  s_tuser,    // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata     // data_lines[7:0], select_drive, done_res,
	                                // error_code[1:0], received_byte[7:0],
	                                // parity_errors[15:0], engine_busy, ack_pending,
	                                // zero fill
);
	import hpbl_pkg::*;

	logic    take;
	result_t res;
	result_t res_q;
	logic    valid_q;

	assign cfg_ready = 1'b1;
	assign s_tready  = !valid_q || m_tready;
	assign take      = s_tvalid && s_tready;

	hpbl_engine #(
		.TIMEOUT_INIT(TIMEOUT_INIT)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_data   (cfg_data),
		.take       (take),
		.kind       (kind_t'(s_tuser)),
		.send_data  (s_tdata[7:0]),
		.ack_pin    (s_tdata[8]),
		.select_pin (s_tdata[9]),
		.paper_pin  (s_tdata[10]),
		.busy_pin   (s_tdata[11]),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (s_tready) begin
			valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {2'b00, res_q};

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps

module testbench;
	import hpbl_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 3000000;
	localparam int unsigned ITEMS_PER_PHASE = 620;

	typedef struct {
		kind_t      k;
		logic [7:0] sd;
		logic       a;
		logic       s;
		logic       p;
		logic       b;
		bit         typed;
		result_t    ex;
	} plan_row_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;

	// Predicted state of the link engine.
	phase_t      lk_phase;
	logic [16:0] lk_polls;
	logic [7:0]  lk_byte;
	logic        lk_bad;
	logic [15:0] lk_perr;
	logic [7:0]  lk_drive;
	logic        lk_sel;
	logic [15:0] lk_limit;

	result_t     due_results[$];
	plan_row_t   plan[$];
	int unsigned src_idle_pct = 8;
	int unsigned snk_stall_pct = 51;
	int unsigned fails = 0;
	int unsigned cycles = 0;
	int unsigned items_in = 0;
	int unsigned results_seen = 0;
	int unsigned timeouts_seen = 0;
	int unsigned parity_fails_seen = 0;

	handshake_port_byte_link uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic result_t advance_link(input kind_t k, input logic [7:0] sd,
			input logic a, input logic s, input logic p, input logic b);
		result_t    r;
		err_t       e;
		logic       done;
		logic [7:0] rx;
		logic       nb;
		e = ERR_OK;
		done = 1'b0;
		rx = '0;
		nb = ~b;
		if (lk_phase == PH_IDLE) begin
			case (k)
				KIND_SEND: begin
					lk_drive = sd;
					lk_sel = 1'b1;
					lk_polls = '0;
					lk_phase = PH_SEND_HI;
				end
				KIND_READ: begin
					lk_polls = '0;
					lk_byte = '0;
					lk_bad = 1'b0;
					lk_phase = PH_RD_HI1;
				end
				KIND_CLEAR: begin
					lk_drive = '0;
					lk_sel = 1'b0;
					lk_perr = '0;
					done = 1'b1;
				end
				default: ;
			endcase
		end else if (lk_polls > {1'b0, lk_limit}) begin
			case (lk_phase)
				PH_SEND_HI: begin
					lk_sel = 1'b0;
					e = ERR_SEND_TIMEOUT;
				end
				PH_SEND_LO: e = ERR_SEND_TIMEOUT;
				PH_RD_LO1: begin
					lk_sel = 1'b0;
					e = ERR_READ_TIMEOUT;
				end
				PH_RD_LO2: begin
					lk_sel = 1'b0;
					e = ERR_REPLY_TIMEOUT;
				end
				default: e = ERR_READ_TIMEOUT;
			endcase
			done = 1'b1;
			lk_phase = PH_IDLE;
			lk_polls = '0;
			timeouts_seen++;
		end else begin
			lk_polls++;
			case (lk_phase)
				PH_SEND_HI: if (a) begin
					lk_sel = 1'b0;
					lk_polls = '0;
					lk_phase = PH_SEND_LO;
				end
				PH_SEND_LO: if (!a) begin
					done = 1'b1;
					lk_polls = '0;
					lk_phase = PH_IDLE;
				end
				PH_RD_HI1: if (a) begin
					lk_byte = {5'b0, nb, p, s};
					lk_sel = 1'b1;
					lk_polls = '0;
					lk_phase = PH_RD_LO1;
				end
				PH_RD_LO1: if (!a) begin
					lk_byte = lk_byte | {2'b0, nb, p, s, 3'b0};
					lk_sel = 1'b0;
					lk_polls = '0;
					lk_phase = PH_RD_HI2;
				end
				PH_RD_HI2: if (a) begin
					lk_byte = lk_byte | {p, s, 6'b0};
					if (nb != ^lk_byte) begin
						lk_drive = PARITY_FAIL_DRIVE;
						lk_bad = 1'b1;
						parity_fails_seen++;
						if (lk_perr != COUNT_MAX)
							lk_perr++;
					end else begin
						lk_drive = '0;
						lk_bad = 1'b0;
					end
					lk_sel = 1'b1;
					lk_polls = '0;
					lk_phase = PH_RD_LO2;
				end
				PH_RD_LO2: if (!a) begin
					lk_sel = 1'b0;
					lk_polls = '0;
					if (lk_bad) begin
						lk_bad = 1'b0;
						lk_byte = '0;
						lk_phase = PH_RD_HI1;
					end else begin
						done = 1'b1;
						rx = lk_byte;
						lk_phase = PH_IDLE;
					end
				end
				default: begin
					lk_phase = PH_IDLE;
					lk_polls = '0;
				end
			endcase
		end
		r = '0;
		r.data_lines = lk_drive;
		r.select_drive = lk_sel;
		r.done_res = done;
		r.error_code = e;
		r.received_byte = rx;
		r.parity_errors = lk_perr;
		r.engine_busy = (lk_phase != PH_IDLE);
		r.ack_pending = a;
		return r;
	endfunction

	function automatic result_t mk_res(input logic [7:0] dl, input logic sel, input logic done,
			input err_t e, input logic [7:0] rx, input logic [15:0] perr, input logic busy,
			input logic ack);
		result_t r;
		r = '0;
		r.data_lines = dl;
		r.select_drive = sel;
		r.done_res = done;
		r.error_code = e;
		r.received_byte = rx;
		r.parity_errors = perr;
		r.engine_busy = busy;
		r.ack_pending = ack;
		return r;
	endfunction

	function automatic void add_row(input kind_t k, input logic [7:0] sd, input logic a,
			input logic s, input logic p, input logic b, input bit typed, input result_t ex);
		plan_row_t row;
		row.k = k;
		row.sd = sd;
		row.a = a;
		row.s = s;
		row.p = p;
		row.b = b;
		row.typed = typed;
		row.ex = ex;
		plan.push_back(row);
	endfunction

	task automatic put_item(input kind_t k, input logic [7:0] sd, input logic a, input logic s,
			input logic p, input logic b, input bit typed, input result_t ex);
		result_t pr;
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= k;
		s_tdata <= {4'b0, b, p, s, a, sd};
		do
			@(posedge clk);
		while (!s_tready);
		pr = advance_link(k, sd, a, s, p, b);
		due_results.push_back(typed ? ex : pr);
		items_in++;
		@(negedge clk);
	endtask

	// Mostly well-formed handshakes with random content; the rest is noise.
	task automatic rand_item(input int unsigned prog_pct, input int unsigned good_pct,
			input bit force_read, output bit counted);
		kind_t       k;
		logic [7:0]  sd;
		logic        a;
		logic        s;
		logic        p;
		logic        b;
		logic        par;
		int unsigned r;
		sd = 8'($urandom);
		a = 1'($urandom);
		s = 1'($urandom);
		p = 1'($urandom);
		b = 1'($urandom);
		if (lk_phase == PH_IDLE) begin
			r = $urandom_range(99);
			if (force_read)
				k = KIND_READ;
			else if (r < 35)
				k = KIND_SEND;
			else if (r < 75)
				k = KIND_READ;
			else if (r < 88)
				k = KIND_CLEAR;
			else
				k = KIND_TICK;
		end else begin
			k = ($urandom_range(99) < 85) ? KIND_TICK : kind_t'($urandom_range(3));
			if ($urandom_range(99) < prog_pct) begin
				case (lk_phase)
					PH_SEND_LO, PH_RD_LO1, PH_RD_LO2: a = 1'b0;
					default: a = 1'b1;
				endcase
			end
			if (lk_phase == PH_RD_HI2 && a) begin
				par = ^(lk_byte | {p, s, 6'b0});
				b = ($urandom_range(99) < good_pct) ? ~par : par;
			end
		end
		counted = !(lk_phase == PH_IDLE && k == KIND_TICK);
		put_item(k, sd, a, s, p, b, 1'b0, '0);
	endtask

	task automatic settle_and_write(input logic [15:0] value);
		bit dummy;
		while (lk_phase != PH_IDLE)
			rand_item(100, 100, 1'b0, dummy);
		s_tvalid <= 1'b0;
		while (due_results.size() != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		lk_limit = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_phase(input int unsigned idle_pct, input int unsigned stall_pct);
		int unsigned n;
		bit          counted;
		src_idle_pct = idle_pct;
		snk_stall_pct = stall_pct;
		n = 0;
		while (n < ITEMS_PER_PHASE) begin
			rand_item(70, 75, 1'b0, counted);
			if (counted)
				n++;
		end
	endtask

	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= snk_stall_pct);

	task automatic check_field(input string nm, input int unsigned e, input int unsigned a);
		if (e != a) begin
			$error("%s: expected %0h, got %0h", nm, e, a);
			fails++;
		end
	endtask

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = result_t'(m_tdata[37:0]);
			results_seen++;
			if (due_results.size() == 0) begin
				$error("unexpected result transfer %0h", m_tdata);
				fails++;
			end else begin
				want = due_results.pop_front();
				check_field("data_lines", want.data_lines, got.data_lines);
				check_field("select_drive", want.select_drive, got.select_drive);
				check_field("done_res", want.done_res, got.done_res);
				check_field("error_code", want.error_code, got.error_code);
				check_field("received_byte", want.received_byte, got.received_byte);
				check_field("parity_errors", want.parity_errors, got.parity_errors);
				check_field("engine_busy", want.engine_busy, got.engine_busy);
				check_field("ack_pending", want.ack_pending, got.ack_pending);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles.", cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		bit dummy;
		lk_phase = PH_IDLE;
		lk_polls = '0;
		lk_byte = '0;
		lk_bad = 1'b0;
		lk_perr = '0;
		lk_drive = '0;
		lk_sel = 1'b0;
		lk_limit = TIMEOUT_RESET;

		add_row(KIND_TICK, 8'h00, 1, 1, 1, 1, 1,
			mk_res(8'h00, 0, 0, ERR_OK, 8'h00, 16'h0, 0, 1));
		add_row(KIND_CLEAR, 8'h00, 0, 0, 0, 0, 1,
			mk_res(8'h00, 0, 1, ERR_OK, 8'h00, 16'h0, 0, 0));
		add_row(KIND_SEND, 8'hff, 0, 0, 0, 0, 1,
			mk_res(8'hff, 1, 0, ERR_OK, 8'h00, 16'h0, 1, 0));
		add_row(KIND_TICK, 8'h00, 0, 1, 1, 1, 0, '0);
		add_row(KIND_READ, 8'h5a, 1, 0, 0, 0, 0, '0);
		add_row(KIND_SEND, 8'h00, 0, 0, 0, 0, 1,
			mk_res(8'hff, 0, 1, ERR_OK, 8'h00, 16'h0, 0, 0));
		add_row(KIND_SEND, 8'h00, 1, 0, 0, 0, 1,
			mk_res(8'h00, 1, 0, ERR_OK, 8'h00, 16'h0, 1, 1));
		add_row(KIND_TICK, 8'h00, 1, 0, 0, 0, 0, '0);
		add_row(KIND_TICK, 8'h00, 0, 0, 0, 0, 0, '0);
		add_row(KIND_READ, 8'h00, 0, 0, 0, 0, 1,
			mk_res(8'h00, 0, 0, ERR_OK, 8'h00, 16'h0, 1, 0));
		add_row(KIND_TICK, 8'h00, 1, 1, 0, 0, 0, '0);
		add_row(KIND_TICK, 8'h00, 0, 0, 1, 1, 0, '0);
		add_row(KIND_TICK, 8'h00, 1, 1, 1, 0, 0, '0);
		add_row(KIND_TICK, 8'h00, 0, 0, 0, 0, 1,
			mk_res(8'h00, 0, 1, ERR_OK, 8'hd5, 16'h0, 0, 0));
		add_row(KIND_READ, 8'h00, 1, 1, 1, 1, 0, '0);
		add_row(KIND_TICK, 8'h00, 1, 0, 0, 1, 0, '0);
		add_row(KIND_TICK, 8'h00, 0, 0, 0, 1, 0, '0);
		add_row(KIND_TICK, 8'h00, 1, 0, 0, 0, 0, '0);
		add_row(KIND_TICK, 8'h00, 0, 0, 0, 0, 0, '0);
		add_row(KIND_TICK, 8'h00, 1, 1, 1, 0, 0, '0);
		add_row(KIND_TICK, 8'h00, 0, 1, 1, 0, 0, '0);
		add_row(KIND_TICK, 8'h00, 1, 1, 1, 1, 0, '0);
		add_row(KIND_TICK, 8'h00, 0, 0, 0, 0, 1,
			mk_res(8'h00, 0, 1, ERR_OK, 8'hff, 16'h1, 0, 0));
		add_row(KIND_CLEAR, 8'haa, 1, 0, 0, 0, 1,
			mk_res(8'h00, 0, 1, ERR_OK, 8'h00, 16'h0, 0, 1));
		add_row(KIND_TICK, 8'h00, 0, 0, 0, 0, 1,
			mk_res(8'h00, 0, 0, ERR_OK, 8'h00, 16'h0, 0, 0));

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[i])
			put_item(plan[i].k, plan[i].sd, plan[i].a, plan[i].s, plan[i].p, plan[i].b,
				plan[i].typed, plan[i].ex);

		settle_and_write(16'd0);
		random_phase(8, 51);
		settle_and_write(16'($urandom_range(1, 6)));
		random_phase(51, 8);
		settle_and_write(16'hffff);
		random_phase(0, 0);

		while (lk_phase != PH_IDLE)
			rand_item(100, 100, 1'b0, dummy);
		put_item(KIND_CLEAR, 8'h00, 0, 0, 0, 0, 1'b0, '0);
		s_tvalid <= 1'b0;

		while (due_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		$display("Sent %0d input transfers and checked %0d results over four timeout settings.",
			items_in, results_seen);
		$display("Saw %0d timeouts and %0d parity failures.",
			timeouts_seen, parity_fails_seen);
		if (fails == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

[handshake_port_byte_link.f]
rtl/hpbl_pkg.sv
rtl/hpbl_engine.sv
rtl/handshake_port_byte_link.sv
test/testbench.sv
